[rtl/core/srp_pkg.sv]
// Shared types, constants and codes for the STUN request parser.
`default_nettype none
package srp_pkg;

    localparam int MAX_DATAGRAM_DEF = 2048;

    localparam int HDR_BYTES = 20;
    localparam int OFFS_W    = 18;
    localparam int SIZE_W    = 12;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 152;

    localparam logic [31:0] STUN_COOKIE  = 32'h2112_A442;
    localparam logic [15:0] TYPE_BINDING = 16'h0001;
    localparam logic [15:0] ATTR_CHANGE  = 16'h0003;
    localparam int FLAG_IP_BIT   = 2;
    localparam int FLAG_PORT_BIT = 1;

    typedef enum logic [1:0] {
        ST_BAD_LEN    = 2'd0,
        ST_BAD_COOKIE = 2'd1,
        ST_BINDING    = 2'd2,
        ST_OTHER      = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } beat_t;

    // Declared from the top bit down, so status sits in the lowest bits.
    typedef struct packed {
        logic [SIZE_W-1:0] datagram_size;
        logic              port_flag;
        logic              ip_flag;
        logic              change_found;
        logic [63:0]       txn_id_low;
        logic [31:0]       txn_id_high;
        logic [15:0]       message_length;
        logic [15:0]       message_type;
        status_t           status;
    } result_t;

endpackage
`default_nettype wire

[rtl/core/srp_in_reg.sv]
// Input register stage holding one received byte and its last mark.
`default_nettype none
module srp_in_reg
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire srp_pkg::beat_t beat_in,
    input  wire logic          advance,
    output logic               beat_valid,
    output srp_pkg::beat_t     beat_out
);

    logic           valid_reg;
    logic           valid_next;
    srp_pkg::beat_t beat_reg;

    // The held beat leaves whenever the parser consumes it, so a new one may enter.
    assign s_tready   = !valid_reg || advance;
    assign beat_valid = valid_reg;
    assign beat_out   = beat_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            beat_reg <= beat_in;
        end
    end

endmodule
`default_nettype wire

[rtl/core/srp_parse.sv]
// Header capture, attribute walk and result decision, one byte per cycle while advance is high.
`default_nettype none
module srp_parse
#(
    parameter int MAX_DATAGRAM = srp_pkg::MAX_DATAGRAM_DEF
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire srp_pkg::beat_t beat,
    output srp_pkg::result_t    result
);

    localparam int CNT_W = $clog2(MAX_DATAGRAM + 1);
    localparam int OW    = srp_pkg::OFFS_W;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      type_reg, type_next;
    logic [15:0]      length_reg, length_next;
    logic [31:0]      cookie_reg, cookie_next;
    logic [31:0]      txn_high_reg, txn_high_next;
    logic [63:0]      txn_low_reg, txn_low_next;
    logic [OW-1:0]    offs_reg, offs_next;
    logic [15:0]      atype_reg, atype_next;
    logic [15:0]      alen_reg, alen_next;
    logic             done_reg, done_next;
    logic [2:0]       flags_reg, flags_next;

    logic [OW-1:0]    pos;
    logic [OW-1:0]    rel_pos;
    logic [15:0]      alen_new;
    logic [16:0]      alen_pad;
    logic [OW:0]      offs_sum;
    logic [7:0]       b;
    logic             found;

    assign b   = beat.data_byte;
    assign pos = OW'(cnt_reg);

    always_comb
    begin
        cnt_next      = cnt_reg;
        type_next     = type_reg;
        length_next   = length_reg;
        cookie_next   = cookie_reg;
        txn_high_next = txn_high_reg;
        txn_low_next  = txn_low_reg;
        offs_next     = offs_reg;
        atype_next    = atype_reg;
        alen_next     = alen_reg;
        done_next     = done_reg;
        flags_next    = flags_reg;
        rel_pos       = pos - offs_reg;
        alen_new      = {alen_reg[7:0], b};
        alen_pad      = ({1'b0, alen_new} + 17'd3) & ~17'd3;
        offs_sum      = {1'b0, offs_reg} + (OW+1)'(4) + (OW+1)'(alen_pad);

        // Bytes past the size limit are dropped without being counted.
        if (advance && (cnt_reg < CNT_W'(MAX_DATAGRAM)))
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg < CNT_W'(2))
            begin
                type_next = {type_reg[7:0], b};
            end
            else if (cnt_reg < CNT_W'(4))
            begin
                length_next = {length_reg[7:0], b};
            end
            else if (cnt_reg < CNT_W'(8))
            begin
                cookie_next = {cookie_reg[23:0], b};
            end
            else if (cnt_reg < CNT_W'(12))
            begin
                txn_high_next = {txn_high_reg[23:0], b};
            end
            else if (cnt_reg < CNT_W'(srp_pkg::HDR_BYTES))
            begin
                txn_low_next = {txn_low_reg[55:0], b};
            end
            else if (!done_reg && (pos >= offs_reg))
            begin
                case (rel_pos)
                    OW'(0): atype_next = {8'h00, b};
                    OW'(1): atype_next = {atype_reg[7:0], b};
                    OW'(2): alen_next  = {8'h00, b};
                    OW'(3):
                    begin
                        alen_next = alen_new;
                        // A complete change-request holds the walk here for its value.
                        if (!((atype_reg == srp_pkg::ATTR_CHANGE) && (alen_new >= 16'd4)))
                        begin
                            offs_next = offs_sum[OW-1:0];
                        end
                    end
                    OW'(7):
                    begin
                        flags_next = b[2:0];
                        done_next  = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        found = 1'b0;
        if ((cnt_next < CNT_W'(srp_pkg::HDR_BYTES)) ||
            ((OW'(srp_pkg::HDR_BYTES) + OW'(length_next)) > OW'(cnt_next)))
        begin
            result.status = srp_pkg::ST_BAD_LEN;
        end
        else if (cookie_next != srp_pkg::STUN_COOKIE)
        begin
            result.status = srp_pkg::ST_BAD_COOKIE;
        end
        else if (type_next == srp_pkg::TYPE_BINDING)
        begin
            result.status = srp_pkg::ST_BINDING;
            found         = done_next;
        end
        else
        begin
            result.status = srp_pkg::ST_OTHER;
        end
        result.message_type   = type_next;
        result.message_length = length_next;
        result.txn_id_high    = txn_high_next;
        result.txn_id_low     = txn_low_next;
        result.change_found   = found;
        result.ip_flag        = found && flags_next[srp_pkg::FLAG_IP_BIT];
        result.port_flag      = found && flags_next[srp_pkg::FLAG_PORT_BIT];
        result.datagram_size  = srp_pkg::SIZE_W'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            type_reg     <= '0;
            length_reg   <= '0;
            cookie_reg   <= '0;
            txn_high_reg <= '0;
            txn_low_reg  <= '0;
            offs_reg     <= OW'(srp_pkg::HDR_BYTES);
            atype_reg    <= '0;
            alen_reg     <= '0;
            done_reg     <= 1'b0;
            flags_reg    <= '0;
        end
        else if (advance && beat.last_byte)
        begin
            // The final byte closes the datagram and the parser starts afresh.
            cnt_reg      <= '0;
            type_reg     <= '0;
            length_reg   <= '0;
            cookie_reg   <= '0;
            txn_high_reg <= '0;
            txn_low_reg  <= '0;
            offs_reg     <= OW'(srp_pkg::HDR_BYTES);
            atype_reg    <= '0;
            alen_reg     <= '0;
            done_reg     <= 1'b0;
            flags_reg    <= '0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            type_reg     <= type_next;
            length_reg   <= length_next;
            cookie_reg   <= cookie_next;
            txn_high_reg <= txn_high_next;
            txn_low_reg  <= txn_low_next;
            offs_reg     <= offs_next;
            atype_reg    <= atype_next;
            alen_reg     <= alen_next;
            done_reg     <= done_next;
            flags_reg    <= flags_next;
        end
    end

endmodule
`default_nettype wire

[rtl/core/srp_out_reg.sv]
// Result register holding one finished report until the sink takes it.
`default_nettype none
module srp_out_reg
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire srp_pkg::result_t res_in,
    input  wire logic             m_tready,
    output logic                  m_tvalid,
    output logic                  free,
    output srp_pkg::result_t      res_out
);

    logic             valid_reg;
    logic             valid_next;
    srp_pkg::result_t res_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule
`default_nettype wire

[rtl/core/stun_request_parser_unit.sv]
// Top level of the STUN request parser: input register, parser and result register.
//
//  Channel | Direction | Beat contents
//  --------+-----------+-------------------------------------------------------
//  s_*     | in        | one datagram byte, tlast on the final byte
//  m_*     | out       | one report per datagram (status, header, change flags, size)
//
// One byte is taken every cycle while s_tready is high. Each byte is held in the input
// register and parsed from there; a datagram's report enters the result register, and
// is valid on m_*, as its final byte leaves the input register. Reset is asynchronous
// and active low; it empties both registers and restarts the parse. s_tready falls only
// while a final byte waits behind a report the sink has not taken.
`default_nettype none
module stun_request_parser_unit
#(
    parameter int MAX_DATAGRAM = srp_pkg::MAX_DATAGRAM_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [7:0] data_byte
    input  wire logic [srp_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [1:0] status, [17:2] message_type, [33:18] message_length, [65:34] txn_id_high,
    // [129:66] txn_id_low, [130] change_found, [131] ip_flag, [132] port_flag,
    // [144:133] datagram_size, [151:145] zero
    output logic [srp_pkg::OUT_TDATA_W-1:0]      m_tdata
);

    localparam int RES_W = $bits(srp_pkg::result_t);

    srp_pkg::beat_t   beat_in;
    srp_pkg::beat_t   beat_q;
    srp_pkg::result_t res_d;
    srp_pkg::result_t res_q;
    logic             beat_valid;
    logic             out_free;
    logic             advance;

    assign beat_in.data_byte = s_tdata;
    assign beat_in.last_byte = s_tlast;

    // A final byte moves on only when the result register can take its report.
    assign advance = beat_valid && (!beat_q.last_byte || out_free);

    srp_in_reg u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .beat_in    (beat_in),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat_out   (beat_q)
    );

    srp_parse #(.MAX_DATAGRAM(MAX_DATAGRAM)) u_parse
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .beat    (beat_q),
        .result  (res_d)
    );

    srp_out_reg u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && beat_q.last_byte),
        .res_in   (res_d),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .free     (out_free),
        .res_out  (res_q)
    );

    assign m_tdata = {(srp_pkg::OUT_TDATA_W - RES_W)'(0), res_q};

endmodule
`default_nettype wire

[rtl/core/srp_checker.sv]
// Port-level checks on the STUN request parser, bound to its top level.
`default_nettype none
module srp_checker
(
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [srp_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // A report that is held back keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("report changed while stalled");

    // Input is throttled only by a blocked report.
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with free result register");

    // Change flags belong to binding requests alone.
    a_change_binding: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] != srp_pkg::ST_BINDING)) |-> (m_tdata[132:130] == 3'b000))
        else $error("change flags on a report that is not a binding request");

    a_change_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[130]) |-> (!m_tdata[131] && !m_tdata[132]))
        else $error("change flags without a change-request attribute");

    // Pad bits above the report stay zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[151:145] == 7'd0))
        else $error("non-zero pad bits in report");

endmodule

bind stun_request_parser_unit srp_checker u_srp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
